FILE: rtl/core/rba_pkg.sv
// ----------------------------------------------------------------------------
// rba_pkg
// Shared constants and types for the ring block allocator.
// ----------------------------------------------------------------------------
package rba_pkg;

    localparam int POOL_SIZE = 4096;
    localparam int OFS_W     = $clog2(POOL_SIZE);
    localparam int LEN_W     = OFS_W + 1;
    localparam int SIZE_W    = 12;
    localparam int STAT_W    = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_FREE   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch transaction, start length read
        logic exec;     // evaluate command, update pointers, load result
        logic fill;     // write new block length at offset 0 after a wrap
    } rba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic wrap;     // current alloc wraps and needs the extra fill write
    } rba_stat_t;

endpackage

FILE: rtl/core/rba_ctrl.sv
// ----------------------------------------------------------------------------
// rba_ctrl
// Sequencer: accept, evaluate, optional wrap write; owns output valid.
// ----------------------------------------------------------------------------
module rba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  rba_pkg::rba_stat_t stat,
    output rba_pkg::rba_cmd_t  cmd
);
    import rba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FILL = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register can take the new transaction
                if (out_free) begin
                    cmd.exec      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = stat.wrap ? S_FILL : S_IDLE;
                end
            end
            S_FILL: begin
                cmd.fill   = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

FILE: rtl/core/rba_datapath.sv
// ----------------------------------------------------------------------------
// rba_datapath
// Head/tail pointers, length memory and result register.
// ----------------------------------------------------------------------------
module rba_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rba_pkg::rba_cmd_t              cmd,
    output rba_pkg::rba_stat_t             stat,
    input  logic                           in_cmd,
    input  logic [rba_pkg::SIZE_W-1:0]     in_alloc_size,
    input  logic [rba_pkg::OFS_W-1:0]      in_free_offset,
    output logic [rba_pkg::STAT_W-1:0]     out_status,
    output logic [rba_pkg::OFS_W-1:0]      out_block_offset,
    output logic [rba_pkg::LEN_W-1:0]      out_freed_length
);
    import rba_pkg::*;

    localparam logic [LEN_W-1:0] POOL_L = LEN_W'(POOL_SIZE);
    localparam logic [LEN_W:0]   POOL_E = (LEN_W + 1)'(POOL_SIZE);

    logic [LEN_W-1:0] len_mem [POOL_SIZE];

    logic              cmd_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [OFS_W-1:0]  foff_reg;
    logic [LEN_W-1:0]  rd_data_reg;

    logic [OFS_W-1:0]  head_reg, head_next;
    logic [OFS_W-1:0]  tail_reg, tail_next;
    logic [OFS_W-1:0]  newest_reg, newest_next;
    logic              nvalid_reg, nvalid_next;

    logic [STAT_W-1:0] status_reg, status_next;
    logic [OFS_W-1:0]  boff_reg, boff_next;
    logic [LEN_W-1:0]  flen_reg, flen_next;

    logic [OFS_W-1:0]  rd_addr;
    logic              mem_we;
    logic [OFS_W-1:0]  mem_waddr;
    logic [LEN_W-1:0]  mem_wdata;

    logic [LEN_W-1:0]  size_ext;
    logic [LEN_W-1:0]  tail_sum;
    logic [LEN_W-1:0]  skip_len;
    logic [LEN_W:0]    free_end;
    logic [OFS_W-1:0]  head_adv;
    logic              wrap_ok;

    assign rd_addr  = (in_cmd == CMD_FREE) ? head_reg : newest_reg;
    assign size_ext = LEN_W'(size_reg);
    assign tail_sum = {1'b0, tail_reg} + size_ext;
    assign skip_len = POOL_L - {1'b0, tail_reg};
    assign free_end = {2'b00, head_reg} + {1'b0, rd_data_reg};

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        newest_next = newest_reg;
        nvalid_next = nvalid_reg;
        status_next = status_reg;
        boff_next   = boff_reg;
        flen_next   = flen_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = size_ext;
        wrap_ok     = 1'b0;
        head_adv    = '0;

        if (cmd_reg == CMD_ALLOC) begin
            status_next = ST_ALLOC_FAIL;
            boff_next   = '0;
            flen_next   = '0;
            if (size_reg != '0) begin
                if (tail_reg < head_reg) begin
                    if (tail_sum < {1'b0, head_reg}) begin
                        status_next = ST_OK;
                        boff_next   = tail_reg;
                        tail_next   = tail_sum[OFS_W-1:0];
                        mem_we      = 1'b1;
                        mem_waddr   = tail_reg;
                    end
                end else if (tail_sum >= POOL_L) begin
                    if (LEN_W'(size_reg) < {1'b0, head_reg}) begin
                        // wrap: grow newest block by skipped tail space,
                        // block length at offset 0 goes in the fill cycle
                        wrap_ok     = 1'b1;
                        status_next = ST_OK;
                        boff_next   = '0;
                        tail_next   = OFS_W'(size_reg);
                        mem_we      = nvalid_reg;
                        mem_waddr   = newest_reg;
                        mem_wdata   = rd_data_reg + skip_len;
                    end
                end else begin
                    status_next = ST_OK;
                    boff_next   = tail_reg;
                    tail_next   = tail_sum[OFS_W-1:0];
                    mem_we      = 1'b1;
                    mem_waddr   = tail_reg;
                end
            end
            if (status_next == ST_OK) begin
                newest_next = wrap_ok ? '0 : tail_reg;
                nvalid_next = 1'b1;
            end
        end else begin
            status_next = ST_BAD_FREE;
            boff_next   = '0;
            flen_next   = '0;
            if (nvalid_reg && (head_reg != tail_reg) && (foff_reg == head_reg)
                    && (free_end <= POOL_E)) begin
                status_next = ST_OK;
                flen_next   = rd_data_reg;
                head_adv    = (free_end < POOL_E) ? free_end[OFS_W-1:0] : '0;
                head_next   = head_adv;
                if (head_adv == tail_reg) begin
                    // pool drained
                    head_next   = '0;
                    tail_next   = '0;
                    newest_next = '0;
                    nvalid_next = 1'b0;
                end
            end
        end

        if (cmd.fill) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = size_ext;
        end else if (!cmd.exec) begin
            mem_we = 1'b0;
        end
    end

    assign stat.wrap = wrap_ok;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            len_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept) begin
            rd_data_reg <= len_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg  <= in_cmd;
            size_reg <= in_alloc_size;
            foff_reg <= in_free_offset;
        end
        if (cmd.exec) begin
            status_reg <= status_next;
            boff_reg   <= boff_next;
            flen_reg   <= flen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            newest_reg <= '0;
            nvalid_reg <= 1'b0;
        end else if (cmd.exec) begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            newest_reg <= newest_next;
            nvalid_reg <= nvalid_next;
        end
    end

    assign out_status       = status_reg;
    assign out_block_offset = boff_reg;
    assign out_freed_length = flen_reg;

endmodule

FILE: rtl/core/ring_block_allocator.sv
// ----------------------------------------------------------------------------
// ring_block_allocator
// Circular pool allocator; blocks are freed strictly in allocation order.
// ----------------------------------------------------------------------------
// Result: the input transaction is latched on acceptance, then evaluated and
//   loaded into the result register in EXEC once that register is free.
// Sequencing: one command at a time, taken only in IDLE; EXEC and, for a wrapping
//   allocation, FILL follow, set by the single-port length memory (registered
//   read, then one or two writes). A result still waiting on m_tready holds EXEC.
// Reset: aresetn synchronous active low; pool empty, head = tail = 0.
//   The length memory is not cleared; unwritten entries may be read, but never affect a result.
module ring_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cmd[0], alloc_size[12:1], free_offset[24:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[1:0], block_offset[13:2], freed_length[26:14]
);
    import rba_pkg::*;

    rba_cmd_t          cmd;
    rba_stat_t         stat;
    logic [STAT_W-1:0] out_status;
    logic [OFS_W-1:0]  out_block_offset;
    logic [LEN_W-1:0]  out_freed_length;

    rba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rba_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_cmd           (s_tdata[0]),
        .in_alloc_size    (s_tdata[12:1]),
        .in_free_offset   (s_tdata[24:13]),
        .out_status       (out_status),
        .out_block_offset (out_block_offset),
        .out_freed_length (out_freed_length)
    );

    assign m_tdata = {5'b0, out_freed_length, out_block_offset, out_status};

endmodule
